// ===== design/lea_pkg.sv =====
package lea_pkg;

   // Largest rho exponent that the power loop runs to.
   localparam int MAX_EXPONENT = 8;
   localparam int EXP_W        = $clog2(MAX_EXPONENT + 1);

   // Field widths of the transactions and registers.
   localparam int ENERGY_W = 32;
   localparam int ADV_W    = 24;
   localparam int DT_W     = 16;
   localparam int FRAC_W   = 17;
   localparam int GAIN_W   = 24;
   localparam int CFG_EXP_W = 4;

   // Bus widths.
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Shared multiplier: unsigned A operand times signed B operand.
   localparam int DRIVE_W = 26;
   localparam int OPA_W   = 32;
   localparam int OPB_W   = 26;
   localparam int PROD_W  = OPA_W + 1 + OPB_W;
   localparam int ACC_W   = 52;
   localparam int THR_W   = 57;

   localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REV_DECAY,
      ST_REV_GAIN,
      ST_REV_SUM,
      ST_FWD_GAIN,
      ST_FWD_SUM,
      ST_POW_CHECK,
      ST_POW_TAKE,
      ST_GAIN_MUL,
      ST_GAIN_TAKE,
      ST_THR_MUL,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_REV_DECAY,
      OP_REV_GAIN,
      OP_FWD_DECAY,
      OP_FWD_GAIN,
      OP_POWER,
      OP_GAIN,
      OP_THRESH
   } op_type;

   typedef enum logic [2:0] {
      REG_DECAY,
      REG_BASE,
      REG_REV_LIMIT,
      REG_FWD_LIMIT,
      REG_FLOOR,
      REG_GAIN,
      REG_EXPONENT
   } reg_index_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      op_type op_sel;
      logic   idle;
      logic   take_item;
      logic   acc_load;
      logic   rev_write;
      logic   fwd_write;
      logic   pow_take;
      logic   term_take;
      logic   rsp_load;
   } ctrl_type;

   // Conditions from the datapath to the sequencer.
   typedef struct packed {
      logic item_valid;
      logic item_error;
      logic pow_more;
      logic out_free;
   } status_type;

endpackage

// ===== design/lea_mul.sv =====
module lea_mul (
   input  logic                               clock,
   input  logic        [lea_pkg::OPA_W-1:0]   op_a,
   input  logic signed [lea_pkg::OPB_W-1:0]   op_b,
   output logic signed [lea_pkg::PROD_W-1:0]  prod_ff
);

   logic signed [lea_pkg::PROD_W-1:0] prod_in;

   // Unsigned A is widened by a zero sign bit so the product is a signed one.
   assign prod_in = $signed({1'b0, op_a}) * op_b;

   // The product is registered before anything uses it.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/lea_ctrl.sv =====
module lea_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  lea_pkg::status_type  status,
   output lea_pkg::ctrl_type    ctrl
);

   lea_pkg::state_type state_ff;
   lea_pkg::state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lea_pkg::ST_IDLE: begin
            if (status.item_valid) begin
               state_in = status.item_error ? lea_pkg::ST_POW_CHECK : lea_pkg::ST_REV_DECAY;
            end
         end
         lea_pkg::ST_REV_DECAY: state_in = lea_pkg::ST_REV_GAIN;
         lea_pkg::ST_REV_GAIN:  state_in = lea_pkg::ST_REV_SUM;
         lea_pkg::ST_REV_SUM:   state_in = lea_pkg::ST_FWD_GAIN;
         lea_pkg::ST_FWD_GAIN:  state_in = lea_pkg::ST_FWD_SUM;
         lea_pkg::ST_FWD_SUM:   state_in = lea_pkg::ST_POW_CHECK;
         lea_pkg::ST_POW_CHECK: begin
            state_in = status.pow_more ? lea_pkg::ST_POW_TAKE : lea_pkg::ST_GAIN_MUL;
         end
         lea_pkg::ST_POW_TAKE:  state_in = lea_pkg::ST_POW_CHECK;
         lea_pkg::ST_GAIN_MUL:  state_in = lea_pkg::ST_GAIN_TAKE;
         lea_pkg::ST_GAIN_TAKE: state_in = lea_pkg::ST_THR_MUL;
         lea_pkg::ST_THR_MUL:   state_in = lea_pkg::ST_FINISH;
         lea_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = lea_pkg::ST_IDLE;
            end
         end
         default: state_in = lea_pkg::ST_IDLE;
      endcase
   end

   // Commands. A multiply issued in one state is consumed in the next one.
   always_comb begin
      ctrl        = '0;
      ctrl.op_sel = lea_pkg::OP_REV_DECAY;
      case (state_ff)
         lea_pkg::ST_IDLE: begin
            ctrl.idle      = 1'b1;
            ctrl.take_item = status.item_valid;
         end
         lea_pkg::ST_REV_DECAY: ctrl.op_sel = lea_pkg::OP_REV_DECAY;
         lea_pkg::ST_REV_GAIN: begin
            ctrl.acc_load = 1'b1;
            ctrl.op_sel   = lea_pkg::OP_REV_GAIN;
         end
         lea_pkg::ST_REV_SUM: begin
            ctrl.rev_write = 1'b1;
            ctrl.op_sel    = lea_pkg::OP_FWD_DECAY;
         end
         lea_pkg::ST_FWD_GAIN: begin
            ctrl.acc_load = 1'b1;
            ctrl.op_sel   = lea_pkg::OP_FWD_GAIN;
         end
         lea_pkg::ST_FWD_SUM:   ctrl.fwd_write = 1'b1;
         lea_pkg::ST_POW_CHECK: ctrl.op_sel = lea_pkg::OP_POWER;
         lea_pkg::ST_POW_TAKE:  ctrl.pow_take = 1'b1;
         lea_pkg::ST_GAIN_MUL:  ctrl.op_sel = lea_pkg::OP_GAIN;
         lea_pkg::ST_GAIN_TAKE: ctrl.term_take = 1'b1;
         lea_pkg::ST_THR_MUL:   ctrl.op_sel = lea_pkg::OP_THRESH;
         lea_pkg::ST_FINISH: begin
            // Keep the threshold product in place while the output is busy.
            ctrl.op_sel   = lea_pkg::OP_THRESH;
            ctrl.rsp_load = status.out_free;
         end
         default: ctrl.op_sel = lea_pkg::OP_REV_DECAY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lea_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted transaction always leaves the idle state.
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.take_item |=> state_ff != lea_pkg::ST_IDLE)
      else $error("sequencer stayed idle after taking a transaction");

   // At most one datapath register is loaded per cycle.
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.acc_load, ctrl.rev_write, ctrl.fwd_write,
                ctrl.pow_take, ctrl.term_take, ctrl.rsp_load}))
      else $error("more than one datapath load in one cycle");

   // A finished result waits while the output register is occupied.
   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lea_pkg::ST_FINISH && !status.out_free) |=> state_ff == lea_pkg::ST_FINISH)
      else $error("finished result left before the output was free");

endmodule

// ===== design/leaky_evidence_accumulator.sv =====
// Channel   Direction  Contents
// req_*     in         advantage, time_step, shaping
// rsp_*     out        reverse_evidence, forward_evidence, ready_res, error
// csr_*     in/out     seven configuration registers at byte address 4*i
//
// An accepted transaction steps through reverse decay, reverse gain, reverse
// sum, forward gain and forward sum, then the rho power loop (a check and a
// take state per extra power), the gain and threshold multiplies, and lands
// in the output register (a zero time step skips the evidence updates); every
// step passes through the one shared multiplier. The sequencer returns to idle before it accepts the next one.
// req_tready is high only while the sequencer is idle; a finished result
// waits in its final state while the output register still holds one.
// Reset is synchronous; it clears both evidence stores and sets the configuration registers to their defaults.
module leaky_evidence_accumulator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [23:0] advantage, [39:24] time_step, [56:40] shaping, rest zero
   input  logic [lea_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] reverse_evidence, [63:32] forward_evidence, [64] ready_res,
   // [65] error, rest zero
   output logic [lea_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lea_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lea_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lea_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int AW = lea_pkg::CSR_ADDR_W;

   lea_pkg::ctrl_type   ctrl;
   lea_pkg::status_type status;

   // Configuration registers.
   logic [lea_pkg::FRAC_W-1:0]    decay_ff, decay_in;
   logic [lea_pkg::ENERGY_W-1:0]  base_ff, base_in;
   logic [lea_pkg::ENERGY_W-1:0]  rlimit_ff, rlimit_in;
   logic [lea_pkg::ENERGY_W-1:0]  flimit_ff, flimit_in;
   logic [lea_pkg::ADV_W-1:0]     floor_ff, floor_in;
   logic [lea_pkg::GAIN_W-1:0]    gain_ff, gain_in;
   logic [lea_pkg::CFG_EXP_W-1:0] exp_ff, exp_in;

   // Evidence stores and per-transaction working registers.
   logic [lea_pkg::ENERGY_W-1:0]       rev_ff, rev_in;
   logic [lea_pkg::ENERGY_W-1:0]       fwd_ff, fwd_in;
   logic signed [lea_pkg::DRIVE_W-1:0] drive_rev_ff, drive_rev_in;
   logic signed [lea_pkg::DRIVE_W-1:0] drive_fwd_ff, drive_fwd_in;
   logic [lea_pkg::DT_W-1:0]           dt_ff, dt_in;
   logic                               err_ff, err_in;
   logic [lea_pkg::FRAC_W-1:0]         rho_ff, rho_in;
   logic [lea_pkg::FRAC_W-1:0]         r_ff, r_in;
   logic [lea_pkg::EXP_W-1:0]          cnt_ff, cnt_in;
   logic [lea_pkg::GAIN_W-1:0]         term_ff, term_in;
   logic signed [lea_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lea_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                               csr_write;
   lea_pkg::reg_index_type             csr_index;
   logic [lea_pkg::FRAC_W-1:0]         lam;
   logic [lea_pkg::CFG_EXP_W:0]        exp_wide;
   logic [lea_pkg::EXP_W-1:0]          p_sat;
   logic signed [lea_pkg::ADV_W-1:0]   adv;
   logic signed [lea_pkg::DRIVE_W-1:0] adv_ext;
   logic signed [lea_pkg::DRIVE_W-1:0] floor_ext;
   logic [lea_pkg::DT_W-1:0]           req_dt;
   logic [lea_pkg::FRAC_W-1:0]         req_rho;
   logic [lea_pkg::FRAC_W-1:0]         rho_sat;
   logic [lea_pkg::OPA_W-1:0]          op_a;
   logic signed [lea_pkg::OPB_W-1:0]   op_b;
   logic [lea_pkg::GAIN_W:0]           thr_factor;
   logic signed [lea_pkg::PROD_W-1:0]  prod_ff;
   logic signed [lea_pkg::ACC_W-1:0]   gain_shift;
   logic signed [lea_pkg::ACC_W-1:0]   sum;
   logic [lea_pkg::ACC_W-17:0]         sum_q;
   logic [lea_pkg::ENERGY_W-1:0]       limit_sel;
   logic [lea_pkg::ENERGY_W-1:0]       upd;
   logic                               ready_bit;

   lea_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   lea_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = lea_pkg::reg_index_type'(csr_paddr[AW-1:2]);

   always_comb begin
      decay_in  = decay_ff;
      base_in   = base_ff;
      rlimit_in = rlimit_ff;
      flimit_in = flimit_ff;
      floor_in  = floor_ff;
      gain_in   = gain_ff;
      exp_in    = exp_ff;
      if (csr_write) begin
         case (csr_index)
            lea_pkg::REG_DECAY:     decay_in  = csr_pwdata[lea_pkg::FRAC_W-1:0];
            lea_pkg::REG_BASE:      base_in   = csr_pwdata[lea_pkg::ENERGY_W-1:0];
            lea_pkg::REG_REV_LIMIT: rlimit_in = csr_pwdata[lea_pkg::ENERGY_W-1:0];
            lea_pkg::REG_FWD_LIMIT: flimit_in = csr_pwdata[lea_pkg::ENERGY_W-1:0];
            lea_pkg::REG_FLOOR:     floor_in  = csr_pwdata[lea_pkg::ADV_W-1:0];
            lea_pkg::REG_GAIN:      gain_in   = csr_pwdata[lea_pkg::GAIN_W-1:0];
            lea_pkg::REG_EXPONENT:  exp_in    = csr_pwdata[lea_pkg::CFG_EXP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         lea_pkg::REG_DECAY:     csr_prdata = lea_pkg::CSR_DATA_W'(decay_ff);
         lea_pkg::REG_BASE:      csr_prdata = base_ff;
         lea_pkg::REG_REV_LIMIT: csr_prdata = rlimit_ff;
         lea_pkg::REG_FWD_LIMIT: csr_prdata = flimit_ff;
         lea_pkg::REG_FLOOR:     csr_prdata = lea_pkg::CSR_DATA_W'(floor_ff);
         lea_pkg::REG_GAIN:      csr_prdata = lea_pkg::CSR_DATA_W'(gain_ff);
         lea_pkg::REG_EXPONENT:  csr_prdata = lea_pkg::CSR_DATA_W'(exp_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // Saturated decay factor and rho exponent.
   always_comb begin
      lam      = (decay_ff > lea_pkg::ONE_Q16) ? lea_pkg::ONE_Q16 : decay_ff;
      exp_wide = {1'b0, exp_ff};
      if (exp_wide == '0) begin
         p_sat = lea_pkg::EXP_W'(1);
      end else if (exp_wide > (lea_pkg::CFG_EXP_W + 1)'(lea_pkg::MAX_EXPONENT)) begin
         p_sat = lea_pkg::EXP_W'(lea_pkg::MAX_EXPONENT);
      end else begin
         p_sat = lea_pkg::EXP_W'(exp_wide);
      end
   end

   // Unpack the incoming transaction and form both drives.
   always_comb begin
      adv          = $signed(req_tdata[lea_pkg::ADV_W-1:0]);
      req_dt       = req_tdata[lea_pkg::ADV_W +: lea_pkg::DT_W];
      req_rho      = req_tdata[lea_pkg::ADV_W + lea_pkg::DT_W +: lea_pkg::FRAC_W];
      rho_sat      = (req_rho > lea_pkg::ONE_Q16) ? lea_pkg::ONE_Q16 : req_rho;
      adv_ext      = {{(lea_pkg::DRIVE_W - lea_pkg::ADV_W){adv[lea_pkg::ADV_W-1]}}, adv};
      floor_ext    = $signed({{(lea_pkg::DRIVE_W - lea_pkg::ADV_W){1'b0}}, floor_ff});
      drive_rev_in = ctrl.take_item ? (adv_ext - floor_ext) : drive_rev_ff;
      drive_fwd_in = ctrl.take_item ? (-adv_ext - floor_ext) : drive_fwd_ff;
      dt_in        = ctrl.take_item ? req_dt : dt_ff;
      err_in       = ctrl.take_item ? (req_dt == '0) : err_ff;
      rho_in       = ctrl.take_item ? rho_sat : rho_ff;
   end

   // Operand selection for the shared multiplier.
   assign thr_factor = (lea_pkg::GAIN_W + 1)'(lea_pkg::ONE_Q16) + {1'b0, term_ff};

   always_comb begin
      case (ctrl.op_sel)
         lea_pkg::OP_REV_DECAY: begin
            op_a = rev_ff;
            op_b = $signed(lea_pkg::OPB_W'(lam));
         end
         lea_pkg::OP_REV_GAIN: begin
            op_a = lea_pkg::OPA_W'(dt_ff);
            op_b = drive_rev_ff;
         end
         lea_pkg::OP_FWD_DECAY: begin
            op_a = fwd_ff;
            op_b = $signed(lea_pkg::OPB_W'(lam));
         end
         lea_pkg::OP_FWD_GAIN: begin
            op_a = lea_pkg::OPA_W'(dt_ff);
            op_b = drive_fwd_ff;
         end
         lea_pkg::OP_POWER: begin
            op_a = lea_pkg::OPA_W'(r_ff);
            op_b = $signed(lea_pkg::OPB_W'(rho_ff));
         end
         lea_pkg::OP_GAIN: begin
            op_a = lea_pkg::OPA_W'(gain_ff);
            op_b = $signed(lea_pkg::OPB_W'(r_ff));
         end
         lea_pkg::OP_THRESH: begin
            op_a = base_ff;
            op_b = $signed(lea_pkg::OPB_W'(thr_factor));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Leak plus gain: the gain product is scaled by 256 to reach 2^-32 units,
   // then the sum is floored at zero, truncated to Q16.16 and clamped.
   always_comb begin
      gain_shift = $signed({prod_ff[lea_pkg::ACC_W-9:0], 8'b0});
      sum        = acc_ff + gain_shift;
      sum_q      = sum[lea_pkg::ACC_W-1:16];
      limit_sel  = ctrl.rev_write ? rlimit_ff : flimit_ff;
      if (sum[lea_pkg::ACC_W-1] || sum == '0) begin
         upd = '0;
      end else if (sum_q > (lea_pkg::ACC_W - 16)'(limit_sel)) begin
         upd = limit_sel;
      end else begin
         upd = sum_q[lea_pkg::ENERGY_W-1:0];
      end
   end

   // Working register updates.
   always_comb begin
      acc_in = ctrl.acc_load ? prod_ff[lea_pkg::ACC_W-1:0] : acc_ff;
      rev_in = ctrl.rev_write ? upd : rev_ff;
      fwd_in = ctrl.fwd_write ? upd : fwd_ff;
      if (ctrl.take_item) begin
         r_in   = rho_sat;
         cnt_in = lea_pkg::EXP_W'(1);
      end else if (ctrl.pow_take) begin
         r_in   = prod_ff[16 +: lea_pkg::FRAC_W];
         cnt_in = cnt_ff + lea_pkg::EXP_W'(1);
      end else begin
         r_in   = r_ff;
         cnt_in = cnt_ff;
      end
      term_in = ctrl.term_take ? prod_ff[16 +: lea_pkg::GAIN_W] : term_ff;
   end

   // Threshold test against E0 * (1 + k * rho^p), exact in 57 bits.
   assign ready_bit = {9'b0, rev_ff, 16'b0} >= $unsigned(prod_ff[lea_pkg::THR_W-1:0]);

   // Output register.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (ctrl.rsp_load) begin
         rsp_data_in  = {6'b0, err_ff, ready_bit, fwd_ff, rev_ff};
         rsp_valid_in = 1'b1;
      end
   end

   assign status.item_valid = req_tvalid;
   assign status.item_error = (req_dt == '0);
   assign status.pow_more   = (cnt_ff < p_sat);
   assign status.out_free   = ~rsp_valid_ff | rsp_tready;

   assign req_tready = ctrl.idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Control state and stores.
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= lea_pkg::ONE_Q16;
         base_ff      <= lea_pkg::ENERGY_W'(lea_pkg::ONE_Q16);
         rlimit_ff    <= '1;
         flimit_ff    <= '1;
         floor_ff     <= '0;
         gain_ff      <= '0;
         exp_ff       <= lea_pkg::CFG_EXP_W'(1);
         rev_ff       <= '0;
         fwd_ff       <= '0;
         r_ff         <= '0;
         cnt_ff       <= lea_pkg::EXP_W'(1);
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         decay_ff     <= decay_in;
         base_ff      <= base_in;
         rlimit_ff    <= rlimit_in;
         flimit_ff    <= flimit_in;
         floor_ff     <= floor_in;
         gain_ff      <= gain_in;
         exp_ff       <= exp_in;
         rev_ff       <= rev_in;
         fwd_ff       <= fwd_in;
         r_ff         <= r_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      drive_rev_ff <= drive_rev_in;
      drive_fwd_ff <= drive_fwd_in;
      dt_ff        <= dt_in;
      rho_ff       <= rho_in;
      term_ff      <= term_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // A zero time step never touches the evidence stores.
   a_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (ctrl.rev_write || ctrl.fwd_write) |-> !err_ff)
      else $error("evidence store written for a zero time step");

   // The power loop never runs past the saturated exponent.
   a_power_bound: assert property (@(posedge clock) disable iff (reset)
      ctrl.pow_take |-> (cnt_ff < p_sat))
      else $error("rho power loop ran past the exponent");

   // Powers of rho stay within one.
   a_power_range: assert property (@(posedge clock) disable iff (reset)
      r_ff <= lea_pkg::ONE_Q16)
      else $error("rho power exceeded one");

   // A loaded result is presented the next cycle.
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |=> rsp_valid_ff && (rsp_data_ff[65] == $past(err_ff)))
      else $error("loaded result not presented");

endmodule
